// ===== hdl/kpvb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpvb_pkg
// Shared types, constants, saturation helpers and the micro-program ROM of
// the position / velocity / bias Kalman filter.
// ----------------------------------------------------------------------------
package kpvb_pkg;

   localparam int WORD_BITS = 48;
   localparam int FRAC_BITS = 32;
   localparam int UFIELD_BITS = WORD_BITS - 1;
   localparam int HALF_BITS = WORD_BITS / 2;
   localparam int NUM_BITS = WORD_BITS + FRAC_BITS;
   localparam int SAT_BITS = 2 * WORD_BITS + 1;
   localparam int CNT_BITS = $clog2(NUM_BITS + 1);

   localparam int REQ_DATA_BITS = ((3 * WORD_BITS + 2 * UFIELD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((3 * WORD_BITS + 7) / 8) * 8;
   localparam int KIND_BITS = 2;

   localparam logic [KIND_BITS-1:0] KIND_PREDICT = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_UPD_POS = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_UPD_VEL = 2'd2;
   localparam logic [KIND_BITS-1:0] KIND_RESET = 2'd3;

   localparam logic CSR_ACCEL_SD = 1'b0;
   localparam logic CSR_BIAS_SD = 1'b1;

   localparam logic [WORD_BITS-1:0] VMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic [WORD_BITS-1:0] VMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   // rounded fixed-point constants, never below one LSB
   localparam logic [63:0] K035_RAW = (64'd35 * (64'd1 << FRAC_BITS) + 64'd50) / 64'd100;
   localparam logic [63:0] K005_RAW = (64'd5 * (64'd1 << FRAC_BITS) + 64'd50) / 64'd100;
   localparam logic [63:0] KRMIN_RAW =
      ((64'd1 << FRAC_BITS) + 64'd50000000) / 64'd100000000;
   localparam logic [63:0] KSMIN_RAW =
      ((64'd1 << FRAC_BITS) + 64'd500000000000) / 64'd1000000000000;
   localparam logic [WORD_BITS-1:0] C035 = WORD_BITS'((K035_RAW == 0) ? 64'd1 : K035_RAW);
   localparam logic [WORD_BITS-1:0] C005 = WORD_BITS'((K005_RAW == 0) ? 64'd1 : K005_RAW);
   localparam logic [WORD_BITS-1:0] CRMIN = WORD_BITS'((KRMIN_RAW == 0) ? 64'd1 : KRMIN_RAW);
   localparam logic [WORD_BITS-1:0] CSMIN = WORD_BITS'((KSMIN_RAW == 0) ? 64'd1 : KSMIN_RAW);
   localparam logic [WORD_BITS-1:0] ACC_SD_RESET = WORD_BITS'(64'd1 << FRAC_BITS);
   localparam logic [WORD_BITS-1:0] BIAS_SD_RESET =
      WORD_BITS'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);

   typedef enum logic [3:0] {
      OP_END, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SHR, OP_HSUM, OP_MAX, OP_SKLE, OP_SKLT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [4:0] dst;
      logic [5:0] a;
      logic [5:0] b;
   } uop_type;

   typedef struct packed {
      logic                 start;
      op_type               op;
      logic [WORD_BITS-1:0] a;
      logic [WORD_BITS-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic                 done;
      logic                 cond;
      logic [WORD_BITS-1:0] res;
   } alu_rsp_type;

   // scratch RAM map
   localparam int A_P0 = 0;
   localparam int A_POS = 9;
   localparam int A_VEL = 10;
   localparam int A_BIAS = 11;
   localparam int T_CA = 12;
   localparam int T_DT2 = 13;
   localparam int T_H = 14;
   localparam int T_X = 15;
   localparam int T_Y = 16;
   localparam int T_A0 = 17;
   localparam int T_QA = 23;
   localparam int T_QB = 24;
   localparam int T_R = 12;
   localparam int T_S = 13;
   localparam int T_IN = 14;
   localparam int T_K0 = 15;
   localparam int T_KX = 18;
   localparam int T_N0 = 19;
   localparam int RAM_DEPTH = 32;

   // operand codes outside the RAM
   localparam int S_ZERO = 32;
   localparam int S_VAL = 33;
   localparam int S_INITV = 34;
   localparam int S_DT = 35;
   localparam int S_VAR = 36;
   localparam int S_WT = 37;
   localparam int S_C035 = 38;
   localparam int S_C005 = 39;
   localparam int S_RMIN = 40;
   localparam int S_SMIN = 41;
   localparam int S_ASD = 42;
   localparam int S_BSD = 43;

   localparam int ROM_DEPTH = 256;
   localparam int PC_BITS = $clog2(ROM_DEPTH);
   localparam logic [PC_BITS-1:0] PRED_BASE = 8'd0;
   localparam logic [PC_BITS-1:0] UPD_POS_BASE = 8'd64;
   localparam logic [PC_BITS-1:0] UPD_VEL_BASE = 8'd128;
   localparam logic [PC_BITS-1:0] RESET_BASE = 8'd192;

   typedef uop_type [ROM_DEPTH-1:0] rom_type;

   function automatic uop_type mk(op_type op, int d, int a, int b);
      uop_type u;
      u.op = op;
      u.dst = 5'(d);
      u.a = 6'(a);
      u.b = 6'(b);
      return u;
   endfunction

   function automatic rom_type build_rom();
      rom_type r;
      int n;
      int c;
      int k;
      int i;
      r = '0;
      // predict
      n = int'(PRED_BASE);
      r[n] = mk(OP_SUB, T_CA, S_VAL, A_BIAS); n++;
      r[n] = mk(OP_MUL, T_DT2, S_DT, S_DT); n++;
      r[n] = mk(OP_SHR, T_H, T_DT2, S_ZERO); n++;
      r[n] = mk(OP_MUL, T_X, A_VEL, S_DT); n++;
      r[n] = mk(OP_MUL, T_Y, T_CA, T_H); n++;
      r[n] = mk(OP_ADD, T_X, T_X, T_Y); n++;
      r[n] = mk(OP_ADD, A_POS, A_POS, T_X); n++;
      r[n] = mk(OP_MUL, T_X, T_CA, S_DT); n++;
      r[n] = mk(OP_ADD, A_VEL, A_VEL, T_X); n++;
      for (c = 0; c < 3; c++) begin
         r[n] = mk(OP_MUL, T_X, S_DT, 3 + c); n++;
         r[n] = mk(OP_ADD, T_X, c, T_X); n++;
         r[n] = mk(OP_MUL, T_Y, T_H, 6 + c); n++;
         r[n] = mk(OP_SUB, T_A0 + c, T_X, T_Y); n++;
         r[n] = mk(OP_MUL, T_Y, S_DT, 6 + c); n++;
         r[n] = mk(OP_SUB, T_A0 + 3 + c, 3 + c, T_Y); n++;
      end
      for (k = 0; k < 3; k++) begin
         // row k of A P, bottom row is P itself
         r[n] = mk(OP_MUL, T_X, S_DT, (k == 2) ? 7 : T_A0 + 3 * k + 1); n++;
         r[n] = mk(OP_ADD, T_X, (k == 2) ? 6 : T_A0 + 3 * k, T_X); n++;
         r[n] = mk(OP_MUL, T_Y, T_H, (k == 2) ? 8 : T_A0 + 3 * k + 2); n++;
         r[n] = mk(OP_SUB, 3 * k, T_X, T_Y); n++;
         r[n] = mk(OP_MUL, T_Y, S_DT, (k == 2) ? 8 : T_A0 + 3 * k + 2); n++;
         r[n] = mk(OP_SUB, 3 * k + 1, (k == 2) ? 7 : T_A0 + 3 * k + 1, T_Y); n++;
         if (k != 2) begin
            r[n] = mk(OP_ADD, 3 * k + 2, T_A0 + 3 * k + 2, S_ZERO); n++;
         end
      end
      r[n] = mk(OP_MUL, T_QA, S_ASD, S_ASD); n++;
      r[n] = mk(OP_MUL, T_X, T_DT2, T_DT2); n++;
      r[n] = mk(OP_SHR, T_X, T_X, S_ZERO); n++;
      r[n] = mk(OP_SHR, T_X, T_X, S_ZERO); n++;
      r[n] = mk(OP_MUL, T_X, T_X, T_QA); n++;
      r[n] = mk(OP_ADD, 0, 0, T_X); n++;
      r[n] = mk(OP_MUL, T_X, T_DT2, T_QA); n++;
      r[n] = mk(OP_ADD, 4, 4, T_X); n++;
      r[n] = mk(OP_MUL, T_QB, S_BSD, S_BSD); n++;
      r[n] = mk(OP_MUL, T_X, S_DT, T_QB); n++;
      r[n] = mk(OP_ADD, 8, 8, T_X); n++;
      r[n] = mk(OP_END, 0, S_ZERO, S_ZERO);
      // scalar updates, position then velocity
      for (i = 0; i < 2; i++) begin
         n = (i == 0) ? int'(UPD_POS_BASE) : int'(UPD_VEL_BASE);
         r[n] = mk(OP_SKLE, 0, S_WT, S_ZERO); n++;
         r[n] = mk(OP_DIV, T_R, S_VAR, S_WT); n++;
         r[n] = mk(OP_MAX, T_R, T_R, S_RMIN); n++;
         r[n] = mk(OP_ADD, T_S, 4 * i, T_R); n++;
         r[n] = mk(OP_SKLT, 0, T_S, S_SMIN); n++;
         r[n] = mk(OP_SUB, T_IN, S_VAL, A_POS + i); n++;
         for (k = 0; k < 3; k++) begin
            r[n] = mk(OP_DIV, T_K0 + k, 3 * k + i, T_S); n++;
         end
         for (k = 0; k < 3; k++) begin
            r[n] = mk(OP_MUL, T_KX, T_K0 + k, T_IN); n++;
            r[n] = mk(OP_ADD, A_POS + k, A_POS + k, T_KX); n++;
         end
         for (k = 0; k < 3; k++) begin
            for (c = 0; c < 3; c++) begin
               r[n] = mk(OP_MUL, T_KX, T_K0 + k, 3 * i + c); n++;
               r[n] = mk(OP_SUB, T_N0 + 3 * k + c, 3 * k + c, T_KX); n++;
            end
         end
         for (k = 0; k < 3; k++) begin
            for (c = 0; c < 3; c++) begin
               r[n] = mk(OP_HSUM, 3 * k + c, T_N0 + 3 * k + c, T_N0 + 3 * c + k); n++;
            end
         end
         r[n] = mk(OP_END, 0, S_ZERO, S_ZERO);
      end
      // state load
      n = int'(RESET_BASE);
      r[n] = mk(OP_ADD, A_POS, S_VAL, S_ZERO); n++;
      r[n] = mk(OP_ADD, A_VEL, S_INITV, S_ZERO); n++;
      r[n] = mk(OP_ADD, A_BIAS, S_ZERO, S_ZERO); n++;
      for (k = 0; k < 9; k++) begin
         r[n] = mk(OP_ADD, k, (k == 0 || k == 4) ? S_C035 : ((k == 8) ? S_C005 : S_ZERO),
                   S_ZERO);
         n++;
      end
      r[n] = mk(OP_END, 0, S_ZERO, S_ZERO);
      return r;
   endfunction

   localparam rom_type ROM = build_rom();

   function automatic logic [WORD_BITS-1:0] mag_of(logic [WORD_BITS-1:0] a);
      return a[WORD_BITS-1] ? (~a + 1'b1) : a;
   endfunction

   function automatic logic [WORD_BITS-1:0] sat_mag(logic neg, logic [SAT_BITS-1:0] mag);
      logic [SAT_BITS-1:0] lim;
      logic [WORD_BITS-1:0] m;
      lim = neg ? SAT_BITS'(VMIN) : SAT_BITS'(VMAX);
      m = mag[WORD_BITS-1:0];
      if (mag > lim)
         return neg ? VMIN : VMAX;
      return neg ? (~m + 1'b1) : m;
   endfunction

   function automatic logic [WORD_BITS-1:0] sat_wide(logic [WORD_BITS:0] s);
      if (s[WORD_BITS] != s[WORD_BITS-1])
         return s[WORD_BITS] ? VMIN : VMAX;
      return s[WORD_BITS-1:0];
   endfunction

endpackage

// ===== hdl/kpvb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpvb_ram
// Generic RAM, one write port, two registered read ports.
// ----------------------------------------------------------------------------
module kpvb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

// ===== hdl/kpvb_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpvb_alu
// Shared saturating arithmetic unit: add, subtract, compare, shift, a
// half-width multiplier over four partial products, bit-serial divider.
// ----------------------------------------------------------------------------
module kpvb_alu (
   input  logic                     clock,
   input  logic                     reset,
   input  kpvb_pkg::alu_req_type    req,
   output kpvb_pkg::alu_rsp_type    rsp
);

   localparam int W = kpvb_pkg::WORD_BITS;
   localparam int F = kpvb_pkg::FRAC_BITS;
   localparam int H = kpvb_pkg::HALF_BITS;
   localparam int N = kpvb_pkg::NUM_BITS;
   localparam int CB = kpvb_pkg::CNT_BITS;
   localparam int SB = kpvb_pkg::SAT_BITS;

   logic                  run_ff, run_in;
   kpvb_pkg::op_type      op_ff, op_in;
   logic [W-1:0]          a_ff, a_in, b_ff, b_in;
   logic [W-1:0]          ma_ff, ma_in, mb_ff, mb_in;
   logic                  neg_ff, neg_in;
   logic [CB-1:0]         cnt_ff, cnt_in, last_ff, last_in;
   logic [W-1:0]          pp_ff, pp_in;
   logic [1:0]            psel_ff, psel_in;
   logic [2*W-1:0]        acc_ff, acc_in;
   logic [W-1:0]          rem_ff, rem_in;
   logic [N-1:0]          num_ff, num_in, q_ff, q_in;

   logic                  done;
   logic [H-1:0]          part_a, part_b;
   logic [2*W-1:0]        pp_shift, mul_rnd;
   logic [W:0]            rem2, sum_ab, dif_ab;
   logic                  ge;
   logic                  rnd_up;

   always_comb begin
      part_a = cnt_ff[0] ? ma_ff[W-1:H] : ma_ff[H-1:0];
      part_b = cnt_ff[1] ? mb_ff[W-1:H] : mb_ff[H-1:0];
      case (psel_ff)
         2'd0: pp_shift = {{W{1'b0}}, pp_ff};
         2'd1: pp_shift = {{W{1'b0}}, pp_ff} << H;
         2'd2: pp_shift = {{W{1'b0}}, pp_ff} << W;
         default: pp_shift = '0;
      endcase
      rem2 = {rem_ff, num_ff[N-1]};
      ge = rem2 >= {1'b0, mb_ff};
      sum_ab = {a_ff[W-1], a_ff} + {b_ff[W-1], b_ff};
      dif_ab = {a_ff[W-1], a_ff} - {b_ff[W-1], b_ff};
      mul_rnd = acc_ff + ((2*W)'(1) << (F - 1));
      rnd_up = rem_ff >= (mb_ff - rem_ff);
      done = run_ff && (cnt_ff == last_ff);
   end

   always_comb begin
      run_in = run_ff;
      op_in = op_ff;
      a_in = a_ff;
      b_in = b_ff;
      ma_in = ma_ff;
      mb_in = mb_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      last_in = last_ff;
      pp_in = pp_ff;
      psel_in = psel_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      num_in = num_ff;
      q_in = q_ff;
      if (req.start) begin
         run_in = 1'b1;
         op_in = req.op;
         a_in = req.a;
         b_in = req.b;
         ma_in = kpvb_pkg::mag_of(req.a);
         mb_in = kpvb_pkg::mag_of(req.b);
         neg_in = req.a[W-1] ^ req.b[W-1];
         cnt_in = '0;
         case (req.op)
            kpvb_pkg::OP_MUL: last_in = CB'(5);
            kpvb_pkg::OP_DIV: last_in = CB'(N);
            default:          last_in = '0;
         endcase
         acc_in = '0;
         rem_in = '0;
         num_in = {kpvb_pkg::mag_of(req.a), {F{1'b0}}};
         q_in = '0;
      end else if (done) begin
         run_in = 1'b0;
      end else if (run_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (op_ff == kpvb_pkg::OP_MUL) begin
            if (cnt_ff < CB'(4)) begin
               pp_in = W'(part_a) * W'(part_b);
               psel_in = 2'(cnt_ff[0]) + 2'(cnt_ff[1]);
            end
            if (cnt_ff != '0) begin
               acc_in = acc_ff + pp_shift;
            end
         end else begin
            rem_in = ge ? W'(rem2 - {1'b0, mb_ff}) : W'(rem2);
            q_in = {q_ff[N-2:0], ge};
            num_in = {num_ff[N-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      rsp.done = done;
      rsp.cond = 1'b0;
      case (op_ff)
         kpvb_pkg::OP_ADD:  rsp.res = kpvb_pkg::sat_wide(sum_ab);
         kpvb_pkg::OP_SUB:  rsp.res = kpvb_pkg::sat_wide(dif_ab);
         kpvb_pkg::OP_MUL:  rsp.res = kpvb_pkg::sat_mag(neg_ff, SB'(mul_rnd[2*W-1:F]));
         kpvb_pkg::OP_DIV:  rsp.res = kpvb_pkg::sat_mag(neg_ff,
                                         SB'({1'b0, q_ff} + (N+1)'(rnd_up)));
         kpvb_pkg::OP_SHR:  rsp.res = {a_ff[W-1], a_ff[W-1:1]};
         kpvb_pkg::OP_HSUM: rsp.res = sum_ab[W:1];
         kpvb_pkg::OP_MAX:  rsp.res = ($signed(a_ff) > $signed(b_ff)) ? a_ff : b_ff;
         kpvb_pkg::OP_SKLE: begin
            rsp.res = a_ff;
            rsp.cond = $signed(a_ff) <= $signed(b_ff);
         end
         kpvb_pkg::OP_SKLT: begin
            rsp.res = a_ff;
            rsp.cond = $signed(a_ff) < $signed(b_ff);
         end
         default:           rsp.res = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
         last_ff <= '0;
         op_ff <= kpvb_pkg::OP_END;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
         last_ff <= last_in;
         op_ff <= op_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      ma_ff <= ma_in;
      mb_ff <= mb_in;
      neg_ff <= neg_in;
      pp_ff <= pp_in;
      psel_ff <= psel_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      num_ff <= num_in;
      q_ff <= q_in;
   end

endmodule

// ===== hdl/axis_kalman_pos_vel_bias_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_kalman_pos_vel_bias_top
// Single-axis Kalman filter (position, velocity, accel bias, 3x3 covariance)
// run as a micro-program over one shared saturating arithmetic unit.
// ----------------------------------------------------------------------------
//  channel   dir  handshake             payload
//  req_*     in   req_tvalid/tready     tuser kind, tdata measurement word
//  rsp_*     out  rsp_tvalid/tready     tuser applied, tdata state estimates
//  csr_*     in   csr_valid/ready       csr_index, csr_data (noise sd regs)
//
//  Each micro-op costs fetch + operand read + execute. A multiply sums four
//  half-width partial products; a divide makes one quotient bit per cycle.
//  A position or velocity update runs four divides. After reset an init pass
//  loads the covariance diagonal and clears state; req_tready stays low until
//  it finishes. req_tready is high only when idle. A finished word parks in
//  the rsp register, so the next word is taken while it waits; a word that
//  ends while the previous result is still unread holds until rsp_tready.
// ----------------------------------------------------------------------------
module axis_kalman_pos_vel_bias_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [1:0] kind
   input  logic [kpvb_pkg::KIND_BITS-1:0]        req_tuser,
   // [47:0] value, [95:48] init_velocity, [142:96] time_step,
   // [189:143] meas_variance, [237:190] meas_weight, rest zero
   input  logic [kpvb_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [0] applied
   output logic                                  rsp_tuser,
   // [47:0] position, [95:48] velocity, [143:96] accel_bias
   output logic [kpvb_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic                                  csr_index,
   input  logic [kpvb_pkg::UFIELD_BITS-1:0]      csr_data
);

   localparam int W = kpvb_pkg::WORD_BITS;
   localparam int U = kpvb_pkg::UFIELD_BITS;
   localparam int PB = kpvb_pkg::PC_BITS;
   localparam int AB = $clog2(kpvb_pkg::RAM_DEPTH);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_FETCH = 5'b00010,
      ST_LOAD  = 5'b00100,
      ST_EXEC  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [PB-1:0]        pc_ff, pc_in;
   logic                 init_ff, init_in;       // power-up load pass
   logic                 applied_ff, applied_in;
   logic [U-1:0]         asd_ff, asd_in, bsd_ff, bsd_in;
   logic [W-1:0]         val_ff, val_in, initv_ff, initv_in, wt_ff, wt_in;
   logic [U-1:0]         dt_ff, dt_in, var_ff, var_in;
   logic [W-1:0]         pos_ff, pos_in, vel_ff, vel_in, bias_ff, bias_in;
   logic                 rsp_valid_ff, rsp_valid_in, rsp_applied_ff, rsp_applied_in;
   logic [3*W-1:0]       rsp_data_ff, rsp_data_in;

   kpvb_pkg::uop_type     uop;
   kpvb_pkg::alu_req_type alu_req;
   kpvb_pkg::alu_rsp_type alu_rsp;
   logic [W-1:0]         ram_qa, ram_qb;
   logic                 ram_we;
   logic                 accept;
   logic                 is_skip;

   // operand source: scratch RAM or one of the fixed / latched words
   function automatic logic [W-1:0] operand(logic [5:0] code, logic [W-1:0] ram_q);
      case (int'(code))
         kpvb_pkg::S_ZERO:  return '0;
         kpvb_pkg::S_VAL:   return init_ff ? '0 : val_ff;
         kpvb_pkg::S_INITV: return init_ff ? '0 : initv_ff;
         kpvb_pkg::S_DT:    return {1'b0, dt_ff};
         kpvb_pkg::S_VAR:   return {1'b0, var_ff};
         kpvb_pkg::S_WT:    return wt_ff;
         kpvb_pkg::S_C035:  return kpvb_pkg::C035;
         kpvb_pkg::S_C005:  return kpvb_pkg::C005;
         kpvb_pkg::S_RMIN:  return kpvb_pkg::CRMIN;
         kpvb_pkg::S_SMIN:  return kpvb_pkg::CSMIN;
         kpvb_pkg::S_ASD:   return {1'b0, asd_ff};
         kpvb_pkg::S_BSD:   return {1'b0, bsd_ff};
         default:           return ram_q;
      endcase
   endfunction

   assign uop = kpvb_pkg::ROM[pc_ff];
   assign req_tready = (state_ff == ST_IDLE);
   assign accept = req_tvalid && req_tready;
   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = rsp_applied_ff;
   assign rsp_tdata = kpvb_pkg::RSP_DATA_BITS'(rsp_data_ff);
   assign is_skip = (uop.op == kpvb_pkg::OP_SKLE) || (uop.op == kpvb_pkg::OP_SKLT);
   assign ram_we = (state_ff == ST_EXEC) && alu_rsp.done && !is_skip;

   always_comb begin
      alu_req.start = (state_ff == ST_LOAD);
      alu_req.op = uop.op;
      alu_req.a = operand(uop.a, ram_qa);
      alu_req.b = operand(uop.b, ram_qb);
   end

   kpvb_ram #(
      .WIDTH(W),
      .DEPTH(kpvb_pkg::RAM_DEPTH)
   ) u_scratch (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (uop.dst),
      .wr_data   (alu_rsp.res),
      .rd_addr_a (uop.a[AB-1:0]),
      .rd_data_a (ram_qa),
      .rd_addr_b (uop.b[AB-1:0]),
      .rd_data_b (ram_qb)
   );

   kpvb_alu u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .rsp   (alu_rsp)
   );

   always_comb begin
      state_in = state_ff;
      pc_in = pc_ff;
      init_in = init_ff;
      applied_in = applied_ff;
      asd_in = asd_ff;
      bsd_in = bsd_ff;
      val_in = val_ff;
      initv_in = initv_ff;
      wt_in = wt_ff;
      dt_in = dt_ff;
      var_in = var_ff;
      pos_in = pos_ff;
      vel_in = vel_ff;
      bias_in = bias_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_applied_in = rsp_applied_ff;
      rsp_data_in = rsp_data_ff;

      if (csr_valid) begin
         case (csr_index)
            kpvb_pkg::CSR_ACCEL_SD: asd_in = csr_data;
            kpvb_pkg::CSR_BIAS_SD:  bsd_in = csr_data;
            default:                asd_in = asd_ff;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // state estimates shadowed for the result word
      if (ram_we) begin
         if (uop.dst == 5'(kpvb_pkg::A_POS)) pos_in = alu_rsp.res;
         if (uop.dst == 5'(kpvb_pkg::A_VEL)) vel_in = alu_rsp.res;
         if (uop.dst == 5'(kpvb_pkg::A_BIAS)) bias_in = alu_rsp.res;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               val_in = req_tdata[W-1:0];
               initv_in = req_tdata[2*W-1:W];
               dt_in = req_tdata[2*W+U-1:2*W];
               var_in = req_tdata[2*W+2*U-1:2*W+U];
               wt_in = req_tdata[3*W+2*U-1:2*W+2*U];
               applied_in = 1'b1;
               case (req_tuser)
                  kpvb_pkg::KIND_PREDICT: pc_in = kpvb_pkg::PRED_BASE;
                  kpvb_pkg::KIND_UPD_POS: pc_in = kpvb_pkg::UPD_POS_BASE;
                  kpvb_pkg::KIND_UPD_VEL: pc_in = kpvb_pkg::UPD_VEL_BASE;
                  default:                pc_in = kpvb_pkg::RESET_BASE;
               endcase
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = (uop.op == kpvb_pkg::OP_END) ? ST_DONE : ST_LOAD;
         end
         ST_LOAD: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (alu_rsp.done) begin
               if (is_skip && alu_rsp.cond) begin
                  applied_in = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  pc_in = pc_ff + 1'b1;
                  state_in = ST_FETCH;
               end
            end
         end
         ST_DONE: begin
            if (init_ff) begin
               init_in = 1'b0;
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_applied_in = applied_ff;
               rsp_data_in = {bias_ff, vel_ff, pos_ff};
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FETCH;
         pc_ff <= kpvb_pkg::RESET_BASE;
         init_ff <= 1'b1;
         applied_ff <= 1'b1;
         asd_ff <= U'(kpvb_pkg::ACC_SD_RESET);
         bsd_ff <= U'(kpvb_pkg::BIAS_SD_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff <= pc_in;
         init_ff <= init_in;
         applied_ff <= applied_in;
         asd_ff <= asd_in;
         bsd_ff <= bsd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      val_ff <= val_in;
      initv_ff <= initv_in;
      wt_ff <= wt_in;
      dt_ff <= dt_in;
      var_ff <= var_in;
      pos_ff <= pos_in;
      vel_ff <= vel_in;
      bias_ff <= bias_in;
      rsp_applied_ff <= rsp_applied_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
